// ===== hw/rtl/erv3_pkg.sv =====
// Package for the roll-pitch-yaw vector rotation core.
// Holds widths, the CORDIC arctangent table and its lookup function; no dependencies.
package erv3_pkg;

    localparam int SincosStagesDef = 16;
    localparam int FracBitsDef     = 16;
    localparam int VecW            = 32;
    localparam int AngW            = 16;
    localparam int PhW             = 33;   // CORDIC phase, 2^32 = 2*pi, plus sign
    localparam int AtanN           = 24;

    localparam logic [31:0] AtanTab [AtanN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    function automatic logic [31:0] atan_at(input int i);
        logic [31:0] v;
        v = '0;
        if (i < AtanN) begin
            v = AtanTab[i];
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/erv3_sincos.sv =====
// Pipelined rotation-mode CORDIC: one stage per register, sine and cosine.
// Depends on erv3_pkg.
module erv3_sincos #(
    parameter int SINCOS_STAGES = erv3_pkg::SincosStagesDef,
    parameter int FRAC_BITS     = erv3_pkg::FracBitsDef
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [erv3_pkg::AngW-1:0] i_ang,
    output logic signed [FRAC_BITS+2:0] o_sin,
    output logic signed [FRAC_BITS+2:0] o_cos
);
    import erv3_pkg::*;

    localparam int XW = FRAC_BITS + 3;
    localparam int KQ30 = 652032874;
    localparam longint XInit =
        ((longint'(KQ30) <<< 1) + (64'sd1 <<< (30 - FRAC_BITS))) >>> (31 - FRAC_BITS);
    localparam int N = SINCOS_STAGES;

    logic signed [XW-1:0]  r_x [N+1];
    logic signed [XW-1:0]  r_y [N+1];
    logic signed [PhW-1:0] r_a [N+1];
    logic                  r_ng [N+1];

    logic signed [PhW-1:0] n_a0;
    logic                  n_ng0;
    logic signed [PhW-1:0] w_a;

    always_comb begin
        w_a   = PhW'(i_ang) <<< 16;
        n_a0  = w_a;
        n_ng0 = 1'b0;
        if (w_a > (PhW'(1) <<< 30)) begin
            n_a0  = w_a - (PhW'(1) <<< 31);
            n_ng0 = 1'b1;
        end else if (w_a < -(PhW'(1) <<< 30)) begin
            n_a0  = w_a + (PhW'(1) <<< 31);
            n_ng0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= XW'(XInit);
            r_y[0]  <= '0;
            r_a[0]  <= n_a0;
            r_ng[0] <= n_ng0;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_stage
        localparam logic signed [PhW-1:0] T = PhW'(atan_at(g));
        localparam int SH = (g < XW) ? g : XW - 1;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ng[g+1] <= r_ng[g];
                if (r_a[g] >= 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> SH);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> SH);
                    r_a[g+1] <= r_a[g] - T;
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> SH);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> SH);
                    r_a[g+1] <= r_a[g] + T;
                end
            end
        end
    end

    assign o_cos = r_ng[N] ? -r_x[N] : r_x[N];
    assign o_sin = r_ng[N] ? -r_y[N] : r_y[N];

endmodule

// ===== hw/rtl/euler_rotate_vector3_core.sv =====
// Top level of the roll-pitch-yaw vector rotation core.
// Depends on erv3_pkg and erv3_sincos.
//
// Rotates a Q15.16 vector by the roll-pitch-yaw matrix (or its transpose when
// the inverse flag is set), saturating each result to 32 bits. One word enters
// per clock while the pipeline advances: one CORDIC stage per register, then
// four product stages for the matrix entries, one stage for the matrix-vector
// products, one for the sum, and one for rounding and saturation.
// The whole pipeline advances when the output register is free or being taken,
// so a stall holds every stage and no word is lost or repeated.
module euler_rotate_vector3_core #(
    parameter int SINCOS_STAGES = erv3_pkg::SincosStagesDef,
    parameter int FRAC_BITS     = erv3_pkg::FracBitsDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // vec_x[31:0], vec_y[63:32], vec_z[95:64], roll[111:96], pitch[127:112],
    // yaw[143:128]
    input  logic [143:0] s_axis_tdata,
    // inverse_flag
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // rot_x[31:0], rot_y[63:32], rot_z[95:64]
    output logic [95:0]  m_axis_tdata
);
    import erv3_pkg::*;

    localparam int CW  = FRAC_BITS + 3;           // sine/cosine width
    localparam int PW  = 2 * CW;                  // product width
    localparam int EW  = FRAC_BITS + 3;           // matrix entry width
    localparam int MW  = EW + VecW;               // entry times component
    localparam int SW  = MW + 2;                  // sum of three
    localparam int LAT = SINCOS_STAGES + 8;
    localparam int DL  = SINCOS_STAGES + 1;       // delay of vector to CORDIC out

    logic adv;
    logic [LAT-1:0] r_vld;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // Sine/cosine units
    logic signed [CW-1:0] sx, cx, sy, cy, sz, cz;
    erv3_sincos #(.SINCOS_STAGES(SINCOS_STAGES), .FRAC_BITS(FRAC_BITS)) u_roll (
        .i_clk(i_clk), .i_en(adv), .i_ang(s_axis_tdata[111:96]), .o_sin(sx), .o_cos(cx));
    erv3_sincos #(.SINCOS_STAGES(SINCOS_STAGES), .FRAC_BITS(FRAC_BITS)) u_pitch (
        .i_clk(i_clk), .i_en(adv), .i_ang(s_axis_tdata[127:112]), .o_sin(sy), .o_cos(cy));
    erv3_sincos #(.SINCOS_STAGES(SINCOS_STAGES), .FRAC_BITS(FRAC_BITS)) u_yaw (
        .i_clk(i_clk), .i_en(adv), .i_ang(s_axis_tdata[143:128]), .o_sin(sz), .o_cos(cz));

    // Delay line for vector and flag
    logic [96:0] r_dly [DL+4];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dly[0] <= {s_axis_tuser, s_axis_tdata[95:0]};
            for (int k = 1; k < DL + 4; k++) r_dly[k] <= r_dly[k-1];
        end
    end

    function automatic logic signed [CW-1:0] rnd(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + (PW'(1) <<< (FRAC_BITS - 1));
        return CW'(t >>> FRAC_BITS);
    endfunction

    // Stage A: single products
    logic signed [PW-1:0] r_sxsy, r_cxsy, r_cycz, r_cysz, r_cxsz, r_cxcz, r_sxcy;
    logic signed [PW-1:0] r_sxsz, r_sxcz, r_cxcy;
    logic signed [CW-1:0] r_a_sy, r_a_sz, r_a_cz;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sxsy <= PW'(sx) * PW'(sy);
            r_cxsy <= PW'(cx) * PW'(sy);
            r_cycz <= PW'(cy) * PW'(cz);
            r_cysz <= PW'(cy) * PW'(sz);
            r_cxsz <= PW'(cx) * PW'(sz);
            r_cxcz <= PW'(cx) * PW'(cz);
            r_sxcy <= PW'(sx) * PW'(cy);
            r_sxsz <= PW'(sx) * PW'(sz);
            r_sxcz <= PW'(sx) * PW'(cz);
            r_cxcy <= PW'(cx) * PW'(cy);
            r_a_sy <= sy;
            r_a_sz <= sz;
            r_a_cz <= cz;
        end
    end

    // Stage B: round first products
    logic signed [CW-1:0] r_b_sxsy, r_b_cxsy, r_b_sz, r_b_cz, r_b_sy;
    logic signed [CW-1:0] r_b_cycz, r_b_cysz, r_b_cxsz, r_b_cxcz, r_b_sxcy, r_b_sxsz;
    logic signed [CW-1:0] r_b_sxcz, r_b_cxcy;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_sxsy <= rnd(r_sxsy);  r_b_cxsy <= rnd(r_cxsy);
            r_b_cycz <= rnd(r_cycz);  r_b_cysz <= rnd(r_cysz);
            r_b_cxsz <= rnd(r_cxsz);  r_b_cxcz <= rnd(r_cxcz);
            r_b_sxcy <= rnd(r_sxcy);  r_b_sxsz <= rnd(r_sxsz);
            r_b_sxcz <= rnd(r_sxcz);  r_b_cxcy <= rnd(r_cxcy);
            r_b_sz <= r_a_sz;  r_b_cz <= r_a_cz;  r_b_sy <= r_a_sy;
        end
    end

    // Stage C: second-level products
    logic signed [PW-1:0] r_c_p0, r_c_p1, r_c_p2, r_c_p3;
    logic signed [CW-1:0] r_c_cycz, r_c_cysz, r_c_cxsz, r_c_cxcz, r_c_sxcy, r_c_sxsz;
    logic signed [CW-1:0] r_c_sxcz, r_c_cxcy, r_c_sy;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_p0 <= PW'(r_b_sxsy) * PW'(r_b_cz);
            r_c_p1 <= PW'(r_b_sxsy) * PW'(r_b_sz);
            r_c_p2 <= PW'(r_b_cxsy) * PW'(r_b_cz);
            r_c_p3 <= PW'(r_b_cxsy) * PW'(r_b_sz);
            r_c_cycz <= r_b_cycz;  r_c_cysz <= r_b_cysz;  r_c_cxsz <= r_b_cxsz;
            r_c_cxcz <= r_b_cxcz;  r_c_sxcy <= r_b_sxcy;  r_c_sxsz <= r_b_sxsz;
            r_c_sxcz <= r_b_sxcz;  r_c_cxcy <= r_b_cxcy;  r_c_sy   <= r_b_sy;
        end
    end

    function automatic logic signed [EW-1:0] clamp1(input logic signed [CW:0] v);
        logic signed [CW:0] one;
        one = (CW+1)'(1) <<< FRAC_BITS;
        if (v > one) return EW'(one);
        if (v < -one) return EW'(-one);
        return EW'(v);
    endfunction

    // Stage D: matrix entries, clamped to [-1, 1]
    logic signed [EW-1:0] r_m [3][3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m[0][0] <= clamp1((CW+1)'(r_c_cycz));
            r_m[0][1] <= clamp1((CW+1)'(r_c_cysz));
            r_m[0][2] <= clamp1(-(CW+1)'(r_c_sy));
            r_m[1][0] <= clamp1((CW+1)'(rnd(r_c_p0)) - (CW+1)'(r_c_cxsz));
            r_m[1][1] <= clamp1((CW+1)'(rnd(r_c_p1)) + (CW+1)'(r_c_cxcz));
            r_m[1][2] <= clamp1((CW+1)'(r_c_sxcy));
            r_m[2][0] <= clamp1((CW+1)'(rnd(r_c_p2)) + (CW+1)'(r_c_sxsz));
            r_m[2][1] <= clamp1((CW+1)'(rnd(r_c_p3)) - (CW+1)'(r_c_sxcz));
            r_m[2][2] <= clamp1((CW+1)'(r_c_cxcy));
        end
    end

    // Stage E: nine entry-times-component products
    logic [96:0] w_vd;
    logic signed [VecW-1:0] w_v [3];
    logic signed [MW-1:0] r_p [3][3];
    assign w_vd = r_dly[DL+3];
    assign w_v[0] = w_vd[31:0];
    assign w_v[1] = w_vd[63:32];
    assign w_v[2] = w_vd[95:64];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p[i][j] <= MW'(w_vd[96] ? r_m[j][i] : r_m[i][j]) * MW'(w_v[j]);
                end
            end
        end
    end

    // Stage F: sums
    logic signed [SW-1:0] r_s [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_s[i] <= SW'(r_p[i][0]) + SW'(r_p[i][1]) + SW'(r_p[i][2]);
            end
        end
    end

    // Stage G: round and saturate into the output register
    logic signed [SW-1:0] w_r [3];
    logic [31:0] n_o [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_r[i] = (r_s[i] + (SW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (w_r[i] > SW'(64'sh7FFFFFFF)) n_o[i] = 32'h7FFFFFFF;
            else if (w_r[i] < -SW'(64'sh80000000)) n_o[i] = 32'h80000000;
            else n_o[i] = w_r[i][31:0];
        end
    end

    logic [95:0] r_out;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= {n_o[2], n_o[1], n_o[0]};
        end
    end
    assign m_axis_tdata = r_out;

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input refused with empty output");
    a_vld_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |=> $stable(r_vld))
        else $error("pipeline moved during stall");
`endif

endmodule
